FILE: hdl/hsmp_pkg.sv
// Shared constants and types for the half-sample mean pyramid block.
package hsmp_pkg;

  // Configuration register layout.
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

  // Geometry limits.
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int ROW_W         = $clog2(MAX_HEIGHT);

  // Pixel and pair-sum widths.
  localparam int PIX_W  = 8;
  localparam int PAIR_W = PIX_W + 1;
  localparam int SUM_W  = PAIR_W + 1;

  // Per-beat decision from the address generator.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [PAIR_W-1:0] pair;
    logic              row_end;
    logic              frame_end;
  } hsmp_step_t;

endpackage

FILE: hdl/hsmp_line_ram.sv
// Line buffer of horizontal pair sums: one write and one registered read port.
module hsmp_line_ram
  import hsmp_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PAIR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PAIR_W-1:0] rd_data
);

  logic [PAIR_W-1:0] mem [DEPTH];
  logic [PAIR_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/hsmp_addr_gen.sv
// Configuration registers, raster counters and per-pixel line buffer decisions.
module hsmp_addr_gen
  import hsmp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int SLOT_W    = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 accept,
  input  logic [PIX_W-1:0]     pixel,
  output hsmp_step_t           step,
  output logic [SLOT_W-1:0]    slot
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int HW    = ROW_W + 1;

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] held_r, held_nxt;

  logic [EW-1:0] width_ext, eff_w, grid_w, col_ext, col_inc;
  logic [HW-1:0] eff_h, grid_h, row_ext, row_inc;
  logic          in_grid;

  // Clamp the configured geometry to the supported range.
  always_comb begin
    width_ext = EW'(width_r);
    if (width_ext < EW'(2)) begin
      eff_w = EW'(2);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
    if (height_r < CFG_W'(2)) begin
      eff_h = HW'(2);
    end else if (HW'(height_r) > HW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_r);
    end
    grid_w = eff_w & ~EW'(1);
    grid_h = eff_h & ~HW'(1);
  end

  // Position decode for the pixel on the input port.
  always_comb begin
    col_ext = EW'(col_r);
    row_ext = HW'(row_r);
    col_inc = col_ext + EW'(1);
    row_inc = row_ext + HW'(1);
    in_grid = (col_ext < grid_w) && (row_ext < grid_h);

    step.pair      = PAIR_W'(held_r) + PAIR_W'(pixel);
    step.wr_en     = accept && in_grid && col_r[0] && !row_r[0];
    step.rd_en     = accept && in_grid && col_r[0] && row_r[0];
    step.row_end   = (col_inc == grid_w);
    step.frame_end = (col_inc == grid_w) && (row_inc == grid_h);
    slot           = SLOT_W'(col_r >> 1);
  end

  // Next state of counters, held pixel and registers.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    held_nxt   = held_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_nxt  = cfg_wdata;
        REG_IMAGE_HEIGHT: height_nxt = cfg_wdata;
      endcase
    end
    if (accept) begin
      if (in_grid && !col_r[0]) begin
        held_nxt = pixel;
      end
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= eff_h) ? '0 : ROW_W'(row_inc);
      end else begin
        col_nxt = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      held_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

FILE: hdl/half_sample_mean_pyramid.sv
// An accepted odd-row pixel passes through the read stage and then the output register to reach the output.
// Throughput: one pixel per cycle while in_stall is low, set by the single read and write port of the line buffer.
// Input stalls only while the read stage and the output register both hold stalled results.
// Reset (rst_n low at a clock edge) clears counters and valid flags and restores the
// registers to 640 by 480; the line buffer is not cleared and needs no clearing pass.
module half_sample_mean_pyramid
  import hsmp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_row_end,
  output logic                 out_frame_end
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  hsmp_step_t        step;
  logic [SLOT_W-1:0] slot;
  logic [PAIR_W-1:0] line_rd_data;
  logic              accept;
  logic              out_load;
  logic [SUM_W-1:0]  sum;

  // Read stage: waits for line buffer data.
  logic              s1_valid_r, s1_valid_nxt;
  logic [PAIR_W-1:0] s1_pair_r;
  logic              s1_row_end_r;
  logic              s1_frame_end_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_row_end_r;
  logic              out_frame_end_r;

  // Handshake: stall only when both stages hold a result that cannot move.
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);

  hsmp_addr_gen #(
    .MAX_WIDTH (MAX_WIDTH),
    .SLOT_W    (SLOT_W)
  ) u_addr_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pixel     (in_pixel_in),
    .step      (step),
    .slot      (slot)
  );

  hsmp_line_ram #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (SLOT_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (step.wr_en),
    .wr_addr (slot),
    .wr_data (step.pair),
    .rd_en   (step.rd_en),
    .rd_addr (slot),
    .rd_data (line_rd_data)
  );

  // Combine the stored pair sum of the even row with the current pair.
  assign sum = SUM_W'(line_rd_data) + SUM_W'(s1_pair_r);

  // Valid flags of both stages.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = step.rd_en;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pair_r      <= step.pair;
      s1_row_end_r   <= step.row_end;
      s1_frame_end_r <= step.frame_end;
    end
    if (out_load) begin
      out_pixel_r     <= sum[SUM_W-1:2];
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

FILE: hdl/hsmp_checker.sv
// Port-level checker for the half-sample mean pyramid and its bind statement.
module hsmp_checker
  import hsmp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_pixel_out,
  input logic             out_row_end,
  input logic             out_frame_end
);

  // The last beat of a frame also closes an output row.
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  // The input backs up only behind a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  // Reset leaves no result on the output.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_pixel_out) && $stable(out_row_end)
       && $stable(out_frame_end)))
    else $error("stalled output beat changed");

endmodule

bind half_sample_mean_pyramid hsmp_checker u_hsmp_checker (.*);

FILE: tb/sv/half_sample_mean_pyramid_test.sv
// Self-checking testbench for the half-sample mean pyramid downsampler.
`timescale 1ns / 1ps

module half_sample_mean_pyramid_test;
  import hsmp_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PIXELS = 1000;
  localparam int REPORT_LIMIT  = 10;
  localparam int LINE_SLOTS    = MAX_WIDTH_DEF / 2;

  // One output beat: the mean and its row and frame markers.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
  } mean_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_row_end;
  logic                 out_frame_end;

  // Predictor state: registers, counters, held pixel and the pair-sum line.
  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;
  int unsigned       src_col;
  int unsigned       src_row;
  logic [PIX_W-1:0]  held_pix;
  logic [PAIR_W-1:0] pair_line [LINE_SLOTS];
  mean_beat_t        expected_means[$];

  // Traffic shaping and bookkeeping.
  bit          bursty_input;
  int unsigned burst_left;
  logic [15:0] stall_pattern;
  logic [3:0]  stall_phase;
  int          stall_hold_request;
  int          stall_hold_left;
  int          cycle_count;
  int          mismatches;
  int          means_checked;
  int          pixels_sent;
  int          settings_used;
  mean_beat_t  seen_mean;
  mean_beat_t  wanted_mean;

  half_sample_mean_pyramid dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  always #6 clk = ~clk;

  // Clamp a register value to the range the block actually uses.
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Advance the predictor by one source pixel and queue any mean it yields.
  function automatic void downsample_pixel(input logic [PIX_W-1:0] pix);
    int unsigned       w;
    int unsigned       h;
    int unsigned       gw;
    int unsigned       gh;
    int unsigned       slot;
    logic [PAIR_W-1:0] pair;
    logic [SUM_W-1:0]  sum;
    mean_beat_t        m;
    w  = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h  = clamp_dim(height_reg, MAX_HEIGHT);
    gw = w & ~32'd1;
    gh = h & ~32'd1;
    if (src_col < gw && src_row < gh) begin
      if (src_col[0] == 1'b0) begin
        held_pix = pix;
      end else begin
        slot = src_col >> 1;
        pair = PAIR_W'(held_pix) + PAIR_W'(pix);
        if (src_row[0] == 1'b0) begin
          pair_line[slot] = pair;
        end else begin
          sum         = SUM_W'(pair_line[slot]) + SUM_W'(pair);
          m.pix       = sum[SUM_W-1:2];
          m.row_end   = (src_col + 1 == gw);
          m.frame_end = m.row_end && (src_row + 1 == gh);
          expected_means.push_back(m);
        end
      end
    end
    // Counters wrap at the clamped bounds, even when a write left them beyond.
    if (src_col + 1 >= w) begin
      src_col = 0;
      src_row = (src_row + 1 >= h) ? 0 : src_row + 1;
    end else begin
      src_col = src_col + 1;
    end
  endfunction

  task automatic note_mismatch(input string what, input mean_beat_t want, input mean_beat_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("MISMATCH %s: expected pix=%0d row_end=%0b frame_end=%0b,", what,
               want.pix, want.row_end, want.frame_end,
               " got pix=%0d row_end=%0b frame_end=%0b",
               got.pix, got.row_end, got.frame_end);
  endtask

  // Output checker: every accepted beat is matched against the oldest expected mean.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen_mean.pix       = out_pixel_out;
      seen_mean.row_end   = out_row_end;
      seen_mean.frame_end = out_frame_end;
      if (expected_means.size() == 0) begin
        note_mismatch("unexpected beat", '0, seen_mean);
      end else begin
        wanted_mean = expected_means.pop_front();
        means_checked++;
        if (seen_mean !== wanted_mean)
          note_mismatch("wrong mean", wanted_mean, seen_mean);
      end
    end
  end

  // Receiver: a long hold-off when requested, otherwise a rotating stall pattern.
  always @(posedge clk) begin
    if (stall_hold_request != 0) begin
      stall_hold_left    = stall_hold_request;
      stall_hold_request = 0;
    end
    if (stall_hold_left != 0) begin
      out_stall <= 1'b1;
      stall_hold_left--;
    end else begin
      out_stall <= stall_pattern[stall_phase];
      stall_phase = stall_phase + 1;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d means still pending.",
               cycle_count, expected_means.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Pick a sender burst style and a receiver stall density for the next phase.
  task automatic shuffle_traffic();
    bursty_input = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0: stall_pattern = '0;
      1: stall_pattern = 16'($urandom() & $urandom());
      2: stall_pattern = 16'($urandom());
      default: stall_pattern = 16'($urandom() | $urandom());
    endcase
    // One free slot in every pattern keeps the output draining.
    stall_pattern[0] = 1'b0;
  endtask

  // Offer one pixel and hold it until the block accepts the beat.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned gap;
    if (bursty_input) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 32);
      end
      burst_left--;
    end
    in_valid    <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    downsample_pixel(pix);
    pixels_sent++;
  endtask

  // Send random pixels until the block is back at the start of a frame.
  task automatic finish_frame();
    while (src_col != 0 || src_row != 0) send_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic send_frame();
    send_pixel(PIX_W'($urandom_range(0, 255)));
    finish_frame();
  endtask

  // Stop offering input and let every pending mean drain out of the pipeline.
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    settings_used++;
  endtask

  // Writes in the middle of a frame: counters beyond the new bounds must wrap.
  task automatic test_midframe_register_writes();
    logic [PIX_W-1:0] row_one [4] = '{8'd255, 8'd255, 8'd0, 8'd0};
    bursty_input  = 1'b0;
    stall_pattern = '0;
    // Start of row 0 at the reset geometry fills two line entries.
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    settle();
    write_reg(REG_IMAGE_WIDTH, 12'd4);
    // The column counter already sits on the new bound, so after this pixel the counters wrap to row 1.
    send_pixel(8'd0);
    foreach (row_one[i]) send_pixel(row_one[i]);
    send_pixel(8'd0);
    send_pixel(8'd255);
    settle();
    // The row counter is now past the new height and wraps at the end of the row.
    write_reg(REG_IMAGE_HEIGHT, 12'd2);
    finish_frame();
    settings_used++;
  endtask

  // Saturated and truncating means on the smallest grid.
  task automatic test_pixel_extremes();
    logic [PIX_W-1:0] frames [12] = '{8'd255, 8'd255, 8'd255, 8'd255,
                                      8'd255, 8'd255, 8'd255, 8'd254,
                                      8'd0,   8'd0,   8'd0,   8'd3};
    set_geometry(12'd2, 12'd2);
    shuffle_traffic();
    foreach (frames[i]) send_pixel(frames[i]);
  endtask

  // Clamped and odd geometries, one frame each.
  task automatic test_geometry_extremes();
    logic [CFG_W-1:0] widths  [4] = '{12'd0, 12'd1, 12'd3, 12'd7};
    logic [CFG_W-1:0] heights [4] = '{12'd1, 12'd0, 12'd3, 12'd5};
    foreach (widths[i]) begin
      set_geometry(widths[i], heights[i]);
      shuffle_traffic();
      send_frame();
    end
  endtask

  // Hold the receiver off long enough that the block fills and stalls its input.
  task automatic test_output_backpressure();
    set_geometry(12'd16, 12'd8);
    bursty_input       = 1'b0;
    stall_pattern      = '0;
    stall_hold_request = 300;
    send_frame();
    send_frame();
  endtask

  // Random geometries and frames, with some frames cut short by a height change.
  task automatic test_random_frames();
    int start;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: set_geometry(CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 3)));
        1: set_geometry(CFG_W'($urandom_range(64, 160)), CFG_W'(2));
        default: set_geometry(CFG_W'($urandom_range(2, 40)), CFG_W'($urandom_range(2, 12)));
      endcase
      shuffle_traffic();
      repeat ($urandom_range(1, 3)) send_frame();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 40)) send_pixel(PIX_W'($urandom_range(0, 255)));
        settle();
        write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 14)));
        finish_frame();
      end
    end
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= REG_IMAGE_WIDTH;
    cfg_wdata          <= '0;
    in_valid           <= 1'b0;
    in_pixel_in        <= '0;
    out_stall          <= 1'b0;
    width_reg           = IMAGE_WIDTH_RST;
    height_reg          = IMAGE_HEIGHT_RST;
    src_col             = 0;
    src_row             = 0;
    held_pix            = '0;
    bursty_input        = 1'b0;
    burst_left          = 0;
    stall_pattern       = '0;
    stall_phase         = '0;
    stall_hold_request  = 0;
    stall_hold_left     = 0;
    cycle_count         = 0;
    mismatches          = 0;
    means_checked       = 0;
    pixels_sent         = 0;
    settings_used       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_midframe_register_writes();
    test_pixel_extremes();
    test_geometry_extremes();
    test_output_backpressure();
    test_random_frames();

    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d source pixels over %0d geometry settings, %0d means checked.",
             pixels_sent, settings_used, means_checked);
    $display("Mid-frame register writes and a 300-cycle output hold-off were included.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
